@@ hdl/ptfe_pkg.sv @@
// Shared types, constants and helpers for the pattern-triggered field extractor.
package ptfe_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int IDX_W        = $clog2(PATTERN_MAX);
  localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
  localparam int RECORD_LIMIT = 256;
  localparam int CNT_W        = $clog2(RECORD_LIMIT + 1);
  localparam int PAT_W        = PATTERN_MAX * 8;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 64;

  localparam logic [7:0] QUOTE_CHAR          = 8'h22;
  localparam logic [3:0] QUOTE_TARGET_RESET  = 4'd4;
  localparam logic [CNT_W-1:0] RECORD_LIMIT_C = CNT_W'(RECORD_LIMIT);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_TARGET = 8'd3;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_EMIT,
    ST_COPY
  } rec_state_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] length;
    logic [3:0]       target;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] p,
                                          input logic [IDX_W-1:0] i);
    return p[{i, 3'b000} +: 8];
  endfunction

endpackage

@@ hdl/ptfe_cell.sv @@
// One window cell: holds a byte, hands it on, compares the incoming byte.
module ptfe_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] pat,
  input  logic       active,
  output logic [7:0] dout,
  output logic       hit
);

  logic [7:0] value;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= din;
    end
  end

  assign dout = value;
  assign hit  = !active || (din == pat);

endmodule

@@ hdl/ptfe_window.sv @@
// Match window: a chain of cells with fill count and windowed pattern compare.
module ptfe_window (
  input  logic                clk,
  input  logic                rst,
  input  ptfe_pkg::cfg_t      cfg,
  input  ptfe_pkg::win_ctrl_t ctrl,
  input  logic [7:0]          text_byte,
  output logic                match
);
  import ptfe_pkg::*;

  logic [7:0]             cell_out [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hits;
  logic [LEN_W-1:0]       fill;
  logic [LEN_W-1:0]       fill_next;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    localparam int I = i;
    logic [LEN_W:0]   pos;
    logic [7:0]       din;
    logic             active;

    assign pos    = (LEN_W + 1)'(I) + {1'b0, cfg.length};
    assign active = pos >= (LEN_W + 1)'(PATTERN_MAX);
    if (i == PATTERN_MAX - 1) begin : g_head
      assign din = text_byte;
    end else begin : g_body
      assign din = cell_out[i + 1];
    end

    ptfe_cell u_cell (
      .clk    (clk),
      .shift  (ctrl.shift),
      .din    (din),
      .pat    (pat_byte(cfg.pattern, pos[IDX_W-1:0])),
      .active (active),
      .dout   (cell_out[i]),
      .hit    (hits[i])
    );
  end

  assign fill_next = (fill == LEN_W'(PATTERN_MAX)) ? fill : fill + 1'b1;
  assign match     = (&hits) && (cfg.length != '0) && (fill_next >= cfg.length);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      fill <= '0;
    end else if (ctrl.shift) begin
      fill <= fill_next;
    end
  end

endmodule

@@ hdl/ptfe_record.sv @@
// Record control: input handshake, pattern replay, quote count and output register.
module ptfe_record (
  input  logic                                clk,
  input  logic                                rst,
  input  ptfe_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          text_byte,
  input  logic                                end_of_text,
  input  logic                                match,
  output ptfe_pkg::win_ctrl_t                 ctrl,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic [7:0]                          record_number,
  output logic                                record_end,
  output logic                                stream_done,
  output logic [ptfe_pkg::CNT_W-1:0]          record_total
);
  import ptfe_pkg::*;

  rec_state_t       state, state_next;
  logic [IDX_W-1:0] emit_idx, emit_idx_next;
  logic [3:0]       quotes, quotes_next;
  logic [CNT_W-1:0] records, records_next;

  logic             load;
  logic [7:0]       ld_byte;
  logic [7:0]       ld_rec;
  logic             ld_end;
  logic             ld_done;
  logic [CNT_W-1:0] ld_total;

  logic             room;
  logic             in_acc;
  logic [7:0]       pb;
  logic [3:0]       q_pat;
  logic [3:0]       q_in;
  logic [CNT_W-1:0] records_inc;

  assign room        = !out_valid || out_ready;
  assign in_ready    = (state != ST_EMIT) && room;
  assign in_acc      = in_valid && in_ready;
  assign pb          = pat_byte(cfg.pattern, emit_idx);
  assign q_pat       = quotes + 4'((pb == QUOTE_CHAR) ? 1 : 0);
  assign q_in        = quotes + 4'((text_byte == QUOTE_CHAR) ? 1 : 0);
  assign records_inc = (records < RECORD_LIMIT_C) ? records + 1'b1 : records;

  always_comb begin
    state_next    = state;
    emit_idx_next = emit_idx;
    quotes_next   = quotes;
    records_next  = records;
    ctrl          = '0;
    load          = 1'b0;
    ld_byte       = '0;
    ld_rec        = records[7:0];
    ld_end        = 1'b0;
    ld_done       = 1'b0;
    ld_total      = '0;
    unique case (state)
      ST_SCAN: begin
        if (in_acc) begin
          if (end_of_text) begin
            load         = 1'b1;
            ld_rec       = '0;
            ld_done      = 1'b1;
            ld_total     = records;
            records_next = '0;
            ctrl.clear   = 1'b1;
          end else begin
            ctrl.shift = 1'b1;
            if (match && (records < RECORD_LIMIT_C)) begin
              state_next    = ST_EMIT;
              emit_idx_next = '0;
              quotes_next   = '0;
            end
          end
        end
      end
      ST_EMIT: begin
        if (room) begin
          load    = 1'b1;
          ld_byte = pb;
          ld_end  = (q_pat == cfg.target);
          if (ld_end) begin
            state_next   = ST_SCAN;
            quotes_next  = '0;
            records_next = records_inc;
            ctrl.clear   = 1'b1;
          end else if ({1'b0, emit_idx} + 1'b1 == cfg.length) begin
            state_next  = ST_COPY;
            quotes_next = q_pat;
          end else begin
            emit_idx_next = emit_idx + 1'b1;
            quotes_next   = q_pat;
          end
        end
      end
      ST_COPY: begin
        if (in_acc) begin
          load = 1'b1;
          if (end_of_text) begin
            ld_end       = 1'b1;
            ld_done      = 1'b1;
            ld_total     = records_inc;
            records_next = '0;
            quotes_next  = '0;
            state_next   = ST_SCAN;
            ctrl.clear   = 1'b1;
          end else begin
            ld_byte     = text_byte;
            ld_end      = (q_in == cfg.target);
            quotes_next = q_in;
            if (ld_end) begin
              state_next   = ST_SCAN;
              quotes_next  = '0;
              records_next = records_inc;
              ctrl.clear   = 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_SCAN;
      quotes  <= '0;
      records <= '0;
    end else begin
      state   <= state_next;
      quotes  <= quotes_next;
      records <= records_next;
    end
  end

  always_ff @(posedge clk) begin
    emit_idx <= emit_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= ld_byte;
      record_number <= ld_rec;
      record_end    <= ld_end;
      stream_done   <= ld_done;
      record_total  <= ld_total;
    end
  end

endmodule

@@ hdl/pattern_triggered_field_extractor.sv @@
// Top level: configuration registers, match window chain and record control.
// A copied word or a summary is registered, shown in the cycle after acceptance;
// a match's first replayed word passes ST_EMIT, then the output register.
// Throughput: one text word per cycle in scan or copy unless the output stalls;
// a match holds input while its pattern words are replayed.
// Reset clears state, window fill, record count and output valid; registers take defaults.
module pattern_triggered_field_extractor (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptfe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ptfe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           text_byte,
  input  logic                                 end_of_text,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte,
  output logic [7:0]                           record_number,
  output logic                                 record_end,
  output logic                                 stream_done,
  output logic [ptfe_pkg::CNT_W-1:0]           record_total
);
  import ptfe_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [4:0]            pattern_length;
  logic [3:0]            quote_target;
  cfg_t                  cfg;
  win_ctrl_t             ctrl;
  logic                  match;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      quote_target   <= QUOTE_TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[4:0];
        REG_QUOTE_TARGET: quote_target   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.pattern = PAT_W'({pattern_high, pattern_low});
  assign cfg.length  = (pattern_length > 5'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : LEN_W'(pattern_length);
  assign cfg.target  = (quote_target == 4'd0) ? 4'd1 : quote_target;

  ptfe_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .text_byte (text_byte),
    .match     (match)
  );

  ptfe_record u_record (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .match         (match),
    .ctrl          (ctrl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .record_number (record_number),
    .record_end    (record_end),
    .stream_done   (stream_done),
    .record_total  (record_total)
  );

endmodule

@@ hdl/ptfe_checker.sv @@
// Port-level checks for the extractor, bound to the top level.
module ptfe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_byte,
  input logic [7:0]                  record_number,
  input logic                        record_end,
  input logic                        stream_done,
  input logic [ptfe_pkg::CNT_W-1:0]  record_total
);
  import ptfe_pkg::*;

  a_summary_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> out_byte == 8'd0)
    else $error("summary word carries a byte");

  a_summary_rec: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done && !record_end |-> record_number == 8'd0)
    else $error("summary without open record names a record");

  a_total_only_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stream_done |-> record_total == '0)
    else $error("record total outside summary word");

  a_total_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> record_total <= RECORD_LIMIT_C)
    else $error("record total beyond limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(record_end))
    else $error("stalled output word changed");

endmodule

bind pattern_triggered_field_extractor ptfe_checker u_ptfe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .record_number (record_number),
  .record_end    (record_end),
  .stream_done   (stream_done),
  .record_total  (record_total)
);

@@ dv/pattern_triggered_field_extractor_tb.sv @@
// Testbench for the field extractor: directed and random streams checked against a predictor.
module pattern_triggered_field_extractor_tb;
  import ptfe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0]       data;
    logic [7:0]       rec;
    logic             last;
    logic             done;
    logic [CNT_W-1:0] total;
  } record_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            text_byte = '0;
  logic                  end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [7:0]            out_byte;
  logic [7:0]            record_number;
  logic                  record_end;
  logic                  stream_done;
  logic [CNT_W-1:0]      record_total;

  // predictor state and register copies
  logic [PAT_W-1:0] pattern_reg = '0;
  logic [4:0]       length_reg = '0;
  logic [3:0]       target_reg = QUOTE_TARGET_RESET;
  logic [7:0]       ext_window [PATTERN_MAX];
  int               ext_fill = 0;
  logic             ext_copying = 1'b0;
  logic [3:0]       ext_quotes = '0;
  logic [CNT_W-1:0] ext_records = '0;

  record_word_t pending_words [$];
  int words_sent = 0;
  int error_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  pattern_triggered_field_extractor DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .record_number (record_number),
    .record_end    (record_end),
    .stream_done   (stream_done),
    .record_total  (record_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < PATTERN_MAX; i++) ext_window[i] = '0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  function automatic void clear_window();
    for (int i = 0; i < PATTERN_MAX; i++) ext_window[i] = '0;
    ext_fill = 0;
  endfunction

  function automatic void close_record();
    ext_copying = 1'b0;
    ext_quotes = '0;
    if (ext_records < RECORD_LIMIT) ext_records++;
    clear_window();
  endfunction

  function automatic void push_word(input logic [7:0] data, input logic [7:0] rec,
                                    input logic last, input logic done,
                                    input logic [CNT_W-1:0] total);
    record_word_t w;
    w.data = data;
    w.rec = rec;
    w.last = last;
    w.done = done;
    w.total = total;
    pending_words.push_back(w);
  endfunction

  function automatic int pattern_len();
    return (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
  endfunction

  task automatic extract_word(input logic [7:0] b, input logic eot);
    int len;
    int tgt;
    int i;
    logic [7:0] rec;
    logic [7:0] pb;
    logic fin;
    bit hit;
    tgt = (target_reg == 0) ? 1 : int'(target_reg);
    len = pattern_len();
    if (eot) begin
      rec = '0;
      fin = 1'b0;
      if (ext_copying) begin
        rec = ext_records[7:0];
        fin = 1'b1;
        close_record();
      end
      push_word(8'h00, rec, fin, 1'b1, ext_records);
      clear_window();
      ext_copying = 1'b0;
      ext_quotes = '0;
      ext_records = '0;
      return;
    end
    if (ext_copying) begin
      rec = ext_records[7:0];
      if (b == QUOTE_CHAR) ext_quotes++;
      fin = (ext_quotes == tgt);
      push_word(b, rec, fin, 1'b0, '0);
      if (fin) close_record();
      return;
    end
    for (i = 0; i < PATTERN_MAX - 1; i++) ext_window[i] = ext_window[i+1];
    ext_window[PATTERN_MAX-1] = b;
    if (ext_fill < PATTERN_MAX) ext_fill++;
    if (len == 0 || ext_fill < len || ext_records >= RECORD_LIMIT) return;
    hit = 1'b1;
    for (i = 0; i < len; i++)
      if (ext_window[PATTERN_MAX-len+i] != pattern_reg[i*8 +: 8]) hit = 1'b0;
    if (!hit) return;
    ext_copying = 1'b1;
    ext_quotes = '0;
    for (i = 0; i < len; i++) begin
      pb = pattern_reg[i*8 +: 8];
      if (pb == QUOTE_CHAR) ext_quotes++;
      fin = (ext_quotes == tgt);
      push_word(pb, ext_records[7:0], fin, 1'b0, '0);
      if (fin) begin
        close_record();
        break;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:  pattern_reg[CFG_DATA_W-1:0] = val;
      REG_PATTERN_HIGH: pattern_reg[PAT_W-1:CFG_DATA_W] = val;
      REG_PATTERN_LEN:  length_reg = val[4:0];
      REG_QUOTE_TARGET: target_reg = val[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    extract_word(b, eot);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == QUOTE_CHAR) ? 8'h23 : b;
  endfunction

  // noise, then the pattern, then a body with quotes sprinkled in
  task automatic send_record_sequence();
    int i;
    int len;
    len = pattern_len();
    repeat ($urandom_range(3)) send_word(8'($urandom_range(255)), 1'b0);
    for (i = 0; i < len; i++) send_word(pattern_reg[i*8 +: 8], 1'b0);
    repeat ($urandom_range(20))
      send_word(($urandom_range(99) < 40) ? QUOTE_CHAR : plain_byte(), 1'b0);
  endtask

  task automatic run_phase(input int items, input logic [4:0] len, input logic [3:0] tgt,
                           input int gap, input int stall);
    logic [PAT_W-1:0] pat;
    int first;
    int i;
    int r;
    gap_pct = gap;
    stall_pct = stall;
    for (i = 0; i < PATTERN_MAX; i++)
      pat[i*8 +: 8] = ($urandom_range(5) == 0) ? QUOTE_CHAR : 8'($urandom_range(255));
    write_reg(REG_PATTERN_LOW, pat[CFG_DATA_W-1:0]);
    write_reg(REG_PATTERN_HIGH, pat[PAT_W-1:CFG_DATA_W]);
    write_reg(REG_PATTERN_LEN, {$urandom(), 27'($urandom()), len});
    write_reg(REG_QUOTE_TARGET, {$urandom(), 28'($urandom()), tgt});
    first = words_sent;
    while (words_sent - first < items) begin
      r = $urandom_range(99);
      if (r < 4) send_word(8'($urandom_range(255)), 1'b1);
      else if (r < 25) send_word(8'($urandom_range(255)), 1'b0);
      else send_record_sequence();
    end
    send_word(8'($urandom_range(255)), 1'b1);
    drain();
  endtask

  task automatic test_defaults();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_match_and_copy();
    write_reg(REG_PATTERN_LOW, 64'({QUOTE_CHAR, 8'h3D, 8'h4E}));
    write_reg(REG_PATTERN_LEN, 64'd3);
    send_word(8'h4E, 1'b0);
    send_word(8'h3D, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_target_in_pattern();
    write_reg(REG_PATTERN_LOW, 64'({8'h62, QUOTE_CHAR, 8'h61}));
    write_reg(REG_QUOTE_TARGET, 64'd1);
    send_word(8'h61, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_end_inside_record();
    write_reg(REG_QUOTE_TARGET, 64'd15);
    send_word(8'h61, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h5A, 1'b1);
    drain();
  endtask

  task automatic test_stray_register();
    write_reg(REG_UNUSED_LOW, '1);
    write_reg(REG_UNUSED_TOP, '1);
    send_word(8'h61, 1'b0);
    send_word(QUOTE_CHAR, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h00, 1'b1);
    drain();
  endtask

  task automatic test_random_phases();
    run_phase(15, 5'd16, 4'd15, 0, 0);
    run_phase(15, 5'd1, 4'd0, 51, 0);
    run_phase(15, 5'd31, 4'd1, 0, 51);
    run_phase(15, 5'd0, 4'd4, 19, 19);
    run_phase(15, 5'd5, 4'd7, 0, 0);
    run_phase(15, 5'd2, 4'd15, 51, 0);
    run_phase(15, 5'd9, 4'd2, 0, 51);
    run_phase(15, 5'd16, 4'd3, 19, 19);
  endtask

  task automatic test_record_limit();
    int extra;
    gap_pct = 19;
    stall_pct = 19;
    write_reg(REG_PATTERN_LOW, 64'(QUOTE_CHAR));
    write_reg(REG_PATTERN_LEN, 64'd1);
    write_reg(REG_QUOTE_TARGET, 64'd1);
    extra = 0;
    while (extra < 8) begin
      send_word(($urandom_range(9) != 0) ? QUOTE_CHAR : 8'($urandom_range(255)), 1'b0);
      if (ext_records >= RECORD_LIMIT) extra++;
    end
    send_word(8'h00, 1'b1);
    drain();
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_output
    record_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %0h, stream_done %0b", out_byte, stream_done);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("record_number", want.rec, record_number);
        check_field("record_end", want.last, record_end);
        check_field("stream_done", want.done, stream_done);
        check_field("record_total", want.total, record_total);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_match_and_copy();
    test_target_in_pattern();
    test_end_inside_record();
    test_stray_register();
    test_random_phases();
    test_record_limit();
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
